FILE: design/cvmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvmp_pkg
// Types and constants shared by the compact vote message parser.
// ----------------------------------------------------------------------------
package cvmp_pkg;

    localparam int DATA_W  = 8;
    localparam int KIND_W  = 3;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 64;
    localparam int ST_W    = 2;
    localparam int POS_W   = 6;
    localparam int SHIFT_W = 6;
    localparam int NUM_CMP_W = IDX_W + 1;

    localparam int ROOT_BYTES = 8;
    localparam int HASH_BYTES = 32;

    localparam logic [SHIFT_W-1:0] LAST_SHIFT = 6'd63;
    localparam logic [SHIFT_W:0]   SHIFT_STEP = 7'd7;
    localparam logic [VAL_W-1:0]   COUNT_FIELD_MAX = 64'd65535;

    // Field kinds as shown on the result channel
    localparam logic [KIND_W-1:0] FK_ROOT    = 3'd0;
    localparam logic [KIND_W-1:0] FK_COUNT   = 3'd1;
    localparam logic [KIND_W-1:0] FK_OFFSET  = 3'd2;
    localparam logic [KIND_W-1:0] FK_CONF    = 3'd3;
    localparam logic [KIND_W-1:0] FK_HASH    = 3'd4;
    localparam logic [KIND_W-1:0] FK_OPTION  = 3'd5;
    localparam logic [KIND_W-1:0] FK_STAMP   = 3'd6;
    localparam logic [KIND_W-1:0] FK_BLOCKID = 3'd7;

    // Result status codes
    localparam logic [ST_W-1:0] ST_FIELD  = 2'd0;
    localparam logic [ST_W-1:0] ST_ACCEPT = 2'd1;
    localparam logic [ST_W-1:0] ST_REJECT = 2'd2;

    typedef enum logic [3:0] {
        PH_ROOT    = 4'd0,
        PH_COUNT   = 4'd1,
        PH_OFFSET  = 4'd2,
        PH_CONF    = 4'd3,
        PH_HASH    = 4'd4,
        PH_OPTION  = 4'd5,
        PH_STAMP   = 4'd6,
        PH_BLOCKID = 4'd7
    } t_phase;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] field_kind;
        logic [IDX_W-1:0]  field_index;
        logic [VAL_W-1:0]  field_value;
        logic [ST_W-1:0]   status;
    } t_result;

endpackage
`default_nettype wire

FILE: design/cvmp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvmp_in_if
// Byte channel into the parser: valid, ready, message byte and end mark.
// ----------------------------------------------------------------------------
interface cvmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface
`default_nettype wire

FILE: design/cvmp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvmp_out_if
// Result channel out of the parser: valid, ready and one parsed field.
// ----------------------------------------------------------------------------
interface cvmp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  field_kind;
    logic [9:0]  field_index;
    logic [63:0] field_value;
    logic [1:0]  status;

    modport source (output valid, output field_kind, output field_index,
                    output field_value, output status, input ready);
    modport sink   (input valid, input field_kind, input field_index,
                    input field_value, input status, output ready);
endinterface
`default_nettype wire

FILE: design/cvmp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvmp_in_stage
// Input register: captures one byte transaction and holds it for the core.
// ----------------------------------------------------------------------------
module cvmp_in_stage
    import cvmp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    cvmp_in_if.sink      i_in,
    input  wire logic    i_take,
    output logic         o_valid,
    output t_in_item     o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Refill in the same cycle the held byte moves on
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.data_byte     <= i_in.data_byte;
            r_item.end_of_buffer <= i_in.end_of_buffer;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

FILE: design/cvmp_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvmp_parse_core
// Parser state and the single-byte step: field checks, accumulation, result.
// ----------------------------------------------------------------------------
module cvmp_parse_core
    import cvmp_pkg::*;
#(
    parameter int MAX_LOCKOUTS = 31
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_item  i_item,
    output logic           o_res_valid,
    output t_result        o_res
);

    localparam int TOT_W = $clog2(MAX_LOCKOUTS + 1);
    localparam logic [VAL_W-1:0] MAX_CNT = VAL_W'(MAX_LOCKOUTS);

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [VAL_W-1:0]   r_acc, n_acc;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [TOT_W-1:0]   r_total, n_total;
    logic [IDX_W-1:0]   r_num, n_num;
    logic               r_over;

    logic [DATA_W-1:0]  b;
    logic               eob;
    logic               fail, emit, done, fin;
    logic [VAL_W-1:0]   val;
    logic [IDX_W-1:0]   idx;
    logic [POS_W-1:0]   pos_inc;
    logic [SHIFT_W:0]   shift_sum;
    logic [NUM_CMP_W-1:0] num_next;
    logic               clr, hold, set_over;

    assign b   = i_item.data_byte;
    assign eob = i_item.end_of_buffer;

    // Field step
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_shift   = r_shift;
        n_total   = r_total;
        n_num     = r_num;
        fail      = 1'b0;
        emit      = 1'b0;
        done      = 1'b0;
        fin       = 1'b0;
        val       = '0;
        pos_inc   = r_pos + POS_W'(1);
        shift_sum = {1'b0, r_shift} + SHIFT_STEP;
        num_next  = {1'b0, r_num} + NUM_CMP_W'(1);
        unique case (r_phase)
            PH_ROOT, PH_STAMP: begin
                n_acc = r_acc | (VAL_W'(b) << {r_pos[2:0], 3'b000});
                n_pos = pos_inc;
                if (pos_inc >= POS_W'(ROOT_BYTES)) begin
                    emit    = 1'b1;
                    val     = n_acc;
                    n_acc   = '0;
                    n_pos   = '0;
                    n_phase = (r_phase == PH_ROOT) ? PH_COUNT : PH_BLOCKID;
                end
            end
            PH_COUNT: begin
                if (r_pos == POS_W'(0)) begin
                    n_acc = VAL_W'(b[6:0]);
                    if (!b[7]) fin = 1'b1;
                    else       n_pos = POS_W'(1);
                end else if (r_pos == POS_W'(1)) begin
                    if (!b[7]) begin
                        if (b == '0) begin
                            fail = 1'b1;
                        end else begin
                            n_acc = r_acc | (VAL_W'(b) << 7);
                            fin   = 1'b1;
                        end
                    end else begin
                        n_acc = r_acc | (VAL_W'(b[6:0]) << 7);
                        n_pos = POS_W'(2);
                    end
                end else begin
                    if (b[7] || b == '0) begin
                        fail = 1'b1;
                    end else begin
                        n_acc = r_acc | (VAL_W'(b) << 14);
                        if (n_acc > COUNT_FIELD_MAX) fail = 1'b1;
                        else                         fin  = 1'b1;
                    end
                end
                if (fin) begin
                    if (n_acc > MAX_CNT) begin
                        fail = 1'b1;
                    end else begin
                        emit    = 1'b1;
                        val     = n_acc;
                        n_total = n_acc[TOT_W-1:0];
                        n_num   = '0;
                        n_pos   = '0;
                        n_acc   = '0;
                        n_shift = '0;
                        n_phase = (val == '0) ? PH_HASH : PH_OFFSET;
                    end
                end
            end
            PH_OFFSET: begin
                n_acc = r_acc | (VAL_W'(b[6:0]) << r_shift);
                if (!b[7]) begin
                    // Only the top group can lose bits off the 64-bit end
                    if (r_shift == LAST_SHIFT && b[6:1] != '0) begin
                        fail = 1'b1;
                    end else if (b == '0 && (r_shift != '0 || n_acc != '0)) begin
                        fail = 1'b1;
                    end else begin
                        emit    = 1'b1;
                        val     = n_acc;
                        n_acc   = '0;
                        n_shift = '0;
                        n_phase = PH_CONF;
                    end
                end else begin
                    if (shift_sum[SHIFT_W]) fail = 1'b1;
                    else                    n_shift = shift_sum[SHIFT_W-1:0];
                end
            end
            PH_CONF: begin
                emit = 1'b1;
                val  = VAL_W'(b);
                if (num_next >= NUM_CMP_W'(r_total)) begin
                    n_num   = '0;
                    n_pos   = '0;
                    n_phase = PH_HASH;
                end else begin
                    n_num   = num_next[IDX_W-1:0];
                    n_phase = PH_OFFSET;
                end
            end
            PH_HASH, PH_BLOCKID: begin
                emit  = 1'b1;
                val   = VAL_W'(b);
                n_pos = pos_inc;
                if (pos_inc >= POS_W'(HASH_BYTES)) begin
                    n_pos = '0;
                    if (r_phase == PH_HASH) n_phase = PH_OPTION;
                    else                    done    = 1'b1;
                end
            end
            PH_OPTION: begin
                if (b > DATA_W'(1)) begin
                    fail = 1'b1;
                end else begin
                    emit    = 1'b1;
                    val     = VAL_W'(b);
                    n_pos   = '0;
                    n_acc   = '0;
                    n_phase = (b != '0) ? PH_STAMP : PH_BLOCKID;
                end
            end
            default: begin
                fail = 1'b1;
            end
        endcase
    end

    always_comb begin
        unique case (r_phase)
            PH_OFFSET, PH_CONF:   idx = r_num;
            PH_HASH, PH_BLOCKID:  idx = IDX_W'(r_pos);
            default:              idx = '0;
        endcase
    end

    // Result and message-level control
    always_comb begin
        o_res_valid       = 1'b0;
        o_res.field_kind  = r_phase[KIND_W-1:0];
        o_res.field_index = idx;
        o_res.field_value = val;
        o_res.status      = ST_FIELD;
        clr               = 1'b0;
        hold              = 1'b0;
        set_over          = 1'b0;
        priority if (r_over) begin
            // Drop trailing bytes until the end mark
            hold = 1'b1;
            clr  = eob;
        end else if (fail || (eob && !done)) begin
            o_res_valid       = 1'b1;
            o_res.field_value = '0;
            o_res.status      = ST_REJECT;
            clr               = eob;
            set_over          = !eob;
        end else if (emit) begin
            o_res_valid  = 1'b1;
            o_res.status = done ? ST_ACCEPT : ST_FIELD;
            clr          = done && eob;
            set_over     = done && !eob;
        end else begin
            // Partial field: no result for this byte
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && clr)) begin
            r_phase <= PH_ROOT;
            r_pos   <= '0;
            r_acc   <= '0;
            r_shift <= '0;
            r_total <= '0;
            r_num   <= '0;
            r_over  <= 1'b0;
        end else if (i_fire && !hold) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_shift <= n_shift;
            r_total <= n_total;
            r_num   <= n_num;
            r_over  <= set_over;
        end
    end

endmodule
`default_nettype wire

FILE: design/cvmp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvmp_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module cvmp_out_stage
    import cvmp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    cvmp_out_if.source    o_out,
    input  wire logic     i_load,
    input  wire logic     i_res_valid,
    input  wire t_result  i_res,
    output logic          o_free
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.field_kind  = r_res.field_kind;
    assign o_out.field_index = r_res.field_index;
    assign o_out.field_value = r_res.field_value;
    assign o_out.status      = r_res.status;

endmodule
`default_nettype wire

FILE: design/compact_vote_message_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compact_vote_message_parser
// Streaming parser for compact vote messages, one byte per transaction.
// Path: a taken byte is held in the input register, parsed by the core and its
// result registered in the result register. Throughput: one byte per cycle while
// the result sink keeps up; a stalled result register holds the input register and core.
// Reset: synchronous, active low; clears the parser to expect a root field and
// empties both registers.
// ----------------------------------------------------------------------------
module compact_vote_message_parser
    import cvmp_pkg::*;
#(
    parameter int MAX_LOCKOUTS = 31
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cvmp_in_if.sink     i_in,
    cvmp_out_if.source  o_out
);

    logic     in_valid;
    t_in_item in_item;
    logic     out_free;
    logic     fire;
    logic     res_valid;
    t_result  res;

    // Advance a byte through the core whenever the result register has room
    assign fire = in_valid && out_free;

    cvmp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    cvmp_parse_core #(
        .MAX_LOCKOUTS (MAX_LOCKOUTS)
    ) u_parse_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cvmp_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_out       (o_out),
        .i_load      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free)
    );

endmodule
`default_nettype wire

FILE: design/cvmp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvmp_checker
// Port-level assertions for the parser, bound to the top level.
// ----------------------------------------------------------------------------
module cvmp_checker
    import cvmp_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [KIND_W-1:0] i_field_kind,
    input wire logic [IDX_W-1:0]  i_field_index,
    input wire logic [VAL_W-1:0]  i_field_value,
    input wire logic [ST_W-1:0]   i_status
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_field_kind)
            && $stable(i_field_index) && $stable(i_field_value) && $stable(i_status))
        else $error("stalled result transaction changed");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_REJECT |-> i_field_value == '0)
        else $error("reject carries a nonzero value");

    a_accept_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_ACCEPT |->
            i_field_kind == FK_BLOCKID && i_field_index == IDX_W'(HASH_BYTES - 1))
        else $error("accept not on the last block id byte");

    a_byte_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_field_kind == FK_HASH || i_field_kind == FK_BLOCKID) |->
            i_field_index < IDX_W'(HASH_BYTES))
        else $error("hash byte index out of range");

endmodule

bind compact_vote_message_parser cvmp_checker u_cvmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_field_kind  (o_out.field_kind),
    .i_field_index (o_out.field_index),
    .i_field_value (o_out.field_value),
    .i_status      (o_out.status)
);
`default_nettype wire

FILE: sim/compact_vote_message_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_vote_message_parser_test
// Self-checking bench for the compact vote message parser. A byte stream of
// directed fragments and random messages, mostly well formed with some
// truncated or corrupted, is pushed through the parser. A shadow parser
// predicts every field and verdict, and each result is checked in order.
// ----------------------------------------------------------------------------
module compact_vote_message_parser_test;
    import cvmp_pkg::*;

    localparam int MAX_LOCKOUTS   = 31;
    localparam int STREAM_ITEMS   = 1100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int HOLD_AFTER     = 300;

    logic i_clk;
    logic i_rst_n;

    cvmp_in_if  in_if ();
    cvmp_out_if out_if ();

    compact_vote_message_parser #(
        .MAX_LOCKOUTS(MAX_LOCKOUTS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_in_item    byte_stream[$];
    t_result     awaited_fields[$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned idle_cycles;

    // shadow parser state
    t_phase        prs_phase;
    logic [5:0]    byte_pos;
    logic [63:0]   accum;
    logic [6:0]    shift_amt;
    logic [15:0]   lock_total;
    logic [9:0]    lock_num;
    bit            over;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow parser
    // ------------------------------------------------------------------------
    function automatic void clear_parser();
        prs_phase  = PH_ROOT;
        byte_pos   = '0;
        accum      = '0;
        shift_amt  = '0;
        lock_total = '0;
        lock_num   = '0;
        over       = 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic eob,
                                      output t_result res);
        logic [KIND_W-1:0] fk;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  val;
        bit                emit;
        bit                fail;
        bit                done;
        bit                fin;
        fk   = KIND_W'(prs_phase);
        idx  = '0;
        val  = '0;
        emit = 1'b0;
        fail = 1'b0;
        done = 1'b0;
        fin  = 1'b0;
        res  = '0;
        if (over) begin
            if (eob)
                clear_parser();
            return 1'b0;
        end
        if (prs_phase == PH_OFFSET || prs_phase == PH_CONF)
            idx = lock_num;
        else if (prs_phase == PH_HASH || prs_phase == PH_BLOCKID)
            idx = IDX_W'(byte_pos);

        case (prs_phase)
            PH_ROOT, PH_STAMP: begin
                accum = accum | (64'(b) << {byte_pos[2:0], 3'b000});
                byte_pos = byte_pos + 1'b1;
                if (byte_pos >= 6'd8) begin
                    emit = 1'b1;
                    val = accum;
                    accum = '0;
                    byte_pos = '0;
                    prs_phase = (prs_phase == PH_ROOT) ? PH_COUNT : PH_BLOCKID;
                end
            end
            PH_COUNT: begin
                if (byte_pos == 6'd0) begin
                    accum = 64'(b & 8'h7F);
                    if (!b[7])
                        fin = 1'b1;
                    else
                        byte_pos = 6'd1;
                end else if (byte_pos == 6'd1) begin
                    if (!b[7]) begin
                        if (b == 8'h00)
                            fail = 1'b1;
                        else begin
                            accum = accum + (64'(b) << 7);
                            fin = 1'b1;
                        end
                    end else begin
                        accum = accum + (64'(b & 8'h7F) << 7);
                        byte_pos = 6'd2;
                    end
                end else begin
                    if (b[7] || b == 8'h00)
                        fail = 1'b1;
                    else begin
                        accum = accum + (64'(b) << 14);
                        if (accum > COUNT_FIELD_MAX)
                            fail = 1'b1;
                        else
                            fin = 1'b1;
                    end
                end
                if (fin) begin
                    if (accum > 64'(MAX_LOCKOUTS))
                        fail = 1'b1;
                    else begin
                        emit = 1'b1;
                        val = accum;
                        lock_total = accum[15:0];
                        lock_num = '0;
                        byte_pos = '0;
                        accum = '0;
                        shift_amt = '0;
                        prs_phase = (lock_total == 16'd0) ? PH_HASH : PH_OFFSET;
                    end
                end
            end
            PH_OFFSET: begin
                accum = accum | (64'(b & 8'h7F) << shift_amt[5:0]);
                if (!b[7]) begin
                    if ((accum >> shift_amt[5:0]) != 64'(b))
                        fail = 1'b1;
                    else if (b == 8'h00 && (shift_amt != 7'd0 || accum != 64'd0))
                        fail = 1'b1;
                    else begin
                        emit = 1'b1;
                        val = accum;
                        accum = '0;
                        shift_amt = '0;
                        prs_phase = PH_CONF;
                    end
                end else begin
                    shift_amt = shift_amt + 7'd7;
                    if (shift_amt >= 7'd64)
                        fail = 1'b1;
                end
            end
            PH_CONF: begin
                emit = 1'b1;
                val = 64'(b);
                if (32'(lock_num) + 1 >= 32'(lock_total)) begin
                    lock_num = '0;
                    byte_pos = '0;
                    prs_phase = PH_HASH;
                end else begin
                    lock_num = lock_num + 1'b1;
                    prs_phase = PH_OFFSET;
                end
            end
            PH_HASH, PH_BLOCKID: begin
                emit = 1'b1;
                val = 64'(b);
                byte_pos = byte_pos + 1'b1;
                if (byte_pos >= 6'd32) begin
                    byte_pos = '0;
                    if (prs_phase == PH_HASH)
                        prs_phase = PH_OPTION;
                    else
                        done = 1'b1;
                end
            end
            PH_OPTION: begin
                if (b > 8'd1)
                    fail = 1'b1;
                else begin
                    emit = 1'b1;
                    val = 64'(b);
                    byte_pos = '0;
                    accum = '0;
                    prs_phase = (b != 8'd0) ? PH_STAMP : PH_BLOCKID;
                end
            end
            default: fail = 1'b1;
        endcase

        res.field_kind  = fk;
        res.field_index = idx;
        if (fail || (eob && !done)) begin
            res.field_value = '0;
            res.status      = ST_REJECT;
            if (eob)
                clear_parser();
            else
                over = 1'b1;
            return 1'b1;
        end
        if (!emit)
            return 1'b0;
        res.field_value = val;
        res.status      = done ? ST_ACCEPT : ST_FIELD;
        if (done) begin
            if (eob)
                clear_parser();
            else
                over = 1'b1;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    function automatic void put_byte(input logic [7:0] b);
        t_in_item it;
        it.data_byte     = b;
        it.end_of_buffer = 1'b0;
        byte_stream.push_back(it);
    endfunction

    function automatic void mark_end();
        byte_stream[byte_stream.size() - 1].end_of_buffer = 1'b1;
    endfunction

    function automatic logic [63:0] rand64();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 64'd0;
        if (r < 20)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_offset();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 64'd0;
        if (r < 15)
            return '1;
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    function automatic void put_le64(input logic [63:0] v);
        for (int i = 0; i < 8; i++)
            put_byte(v[8*i +: 8]);
    endfunction

    function automatic void put_leb(input logic [63:0] v);
        while (v >= 64'h80) begin
            put_byte({1'b1, v[6:0]});
            v = v >> 7;
        end
        put_byte({1'b0, v[6:0]});
    endfunction

    function automatic void put_random_bytes(input int unsigned n);
        repeat (n) put_byte(8'($urandom));
    endfunction

    // each variant fails on its last byte
    function automatic void put_bad_count();
        case ($urandom_range(0, 5))
            0: put_byte(8'($urandom_range(32, 127)));
            1: begin
                put_byte({1'b1, 7'($urandom)});
                put_byte(8'($urandom_range(1, 127)));
            end
            2: begin
                put_byte({1'b1, 7'($urandom)});
                put_byte(8'h00);
            end
            3: begin
                put_byte({1'b1, 7'($urandom)});
                put_byte({1'b1, 7'($urandom)});
                put_byte($urandom_range(0, 1) ? 8'h00 : {1'b1, 7'($urandom)});
            end
            4: begin
                put_byte({1'b1, 7'($urandom)});
                put_byte({1'b1, 7'($urandom)});
                put_byte(8'($urandom_range(4, 127)));
            end
            default: begin
                put_byte({1'b1, 7'($urandom)});
                put_byte({1'b1, 7'($urandom)});
                put_byte(8'($urandom_range(1, 3)));
            end
        endcase
    endfunction

    function automatic void put_bad_offset();
        case ($urandom_range(0, 2))
            0: begin
                // redundant zero group at the end
                put_leb(rand_offset() >> 8);
                byte_stream[byte_stream.size() - 1].data_byte[7] = 1'b1;
                put_byte(8'h00);
            end
            1: repeat (10) put_byte({1'b1, 7'($urandom)});
            default: begin
                // top group holds more than the one bit left
                repeat (9) put_byte({1'b1, 7'($urandom)});
                put_byte(8'($urandom_range(2, 127)));
            end
        endcase
    endfunction

    function automatic void finish_broken();
        if ($urandom_range(0, 1))
            mark_end();
        else begin
            put_random_bytes($urandom_range(0, 3));
            put_byte(8'($urandom));
            mark_end();
        end
    endfunction

    typedef enum int {FLAW_NONE, FLAW_CUT, FLAW_COUNT, FLAW_OFFSET, FLAW_OPTION,
                      FLAW_NOISE} t_flaw;

    function automatic void add_message();
        t_flaw       flaw;
        int unsigned r;
        int unsigned lockouts;
        int unsigned bad_at;
        int unsigned start;
        int unsigned cut_at;
        bit          with_stamp;
        start = byte_stream.size();
        r = $urandom_range(0, 99);
        if (r < 55)
            flaw = FLAW_NONE;
        else if (r < 67)
            flaw = FLAW_CUT;
        else if (r < 77)
            flaw = FLAW_COUNT;
        else if (r < 87)
            flaw = FLAW_OFFSET;
        else if (r < 95)
            flaw = FLAW_OPTION;
        else
            flaw = FLAW_NOISE;

        if (flaw == FLAW_NOISE) begin
            repeat ($urandom_range(1, 20))
                put_byte(8'($urandom));
            foreach (byte_stream[i])
                if (i >= start && $urandom_range(0, 5) == 0)
                    byte_stream[i].end_of_buffer = 1'b1;
            mark_end();
            return;
        end

        r = $urandom_range(0, 99);
        if (r < 20)
            lockouts = 0;
        else if (r < 70)
            lockouts = $urandom_range(1, 4);
        else if (r < 90)
            lockouts = $urandom_range(5, 30);
        else
            lockouts = MAX_LOCKOUTS;
        if (flaw == FLAW_OFFSET && lockouts == 0)
            lockouts = $urandom_range(1, 4);
        with_stamp = 1'($urandom_range(0, 1));

        put_le64(rand64());
        if (flaw == FLAW_COUNT) begin
            put_bad_count();
            finish_broken();
            return;
        end
        put_byte(8'(lockouts));
        bad_at = (lockouts > 0) ? $urandom_range(0, lockouts - 1) : 0;
        for (int j = 0; j < lockouts; j++) begin
            if (flaw == FLAW_OFFSET && j == bad_at) begin
                put_bad_offset();
                finish_broken();
                return;
            end
            put_leb(rand_offset());
            put_byte(8'($urandom));
        end
        put_random_bytes(HASH_BYTES);
        if (flaw == FLAW_OPTION) begin
            put_byte(8'($urandom_range(2, 255)));
            finish_broken();
            return;
        end
        put_byte(8'(with_stamp));
        if (with_stamp)
            put_le64(rand64());
        put_random_bytes(HASH_BYTES);

        if (flaw == FLAW_CUT) begin
            cut_at = $urandom_range(start + 1, byte_stream.size() - 1);
            while (byte_stream.size() > cut_at)
                void'(byte_stream.pop_back());
            mark_end();
        end else if ($urandom_range(0, 1)) begin
            mark_end();
        end else begin
            put_random_bytes($urandom_range(1, 4));
            mark_end();
        end
    endfunction

    function automatic int unsigned draw_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------------
    int unsigned tx_wait;
    bit          tx_calm;
    t_result     predicted;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            tx_wait = 0;
            tx_calm = 1'b0;
            clear_parser();
        end else begin
            if (in_if.valid && in_if.ready) begin
                if (parse_byte(in_if.data_byte, in_if.end_of_buffer, predicted))
                    awaited_fields.push_back(predicted);
                void'(byte_stream.pop_front());
                tx_wait = draw_gap(tx_calm);
                if ($urandom_range(0, 99) == 0)
                    tx_calm = !tx_calm;
            end
            if (tx_wait != 0) begin
                tx_wait--;
                in_if.valid <= 1'b0;
            end else if (byte_stream.size() != 0) begin
                in_if.valid         <= 1'b1;
                in_if.data_byte     <= byte_stream[0].data_byte;
                in_if.end_of_buffer <= byte_stream[0].end_of_buffer;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result ready, with one long hold-off to back the parser up
    // ------------------------------------------------------------------------
    int unsigned rx_wait;
    bit          rx_calm;
    bit          hold_done;
    int unsigned rx_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_wait = 0;
            rx_calm = 1'b0;
            hold_done = 1'b0;
        end else if (rx_wait != 0) begin
            rx_wait--;
            out_if.ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rx_wait = LONG_HOLD;
            out_if.ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0)
                rx_calm = !rx_calm;
            rx_gap = draw_gap(rx_calm);
            if (rx_gap == 0)
                out_if.ready <= 1'b1;
            else begin
                rx_wait = rx_gap - 1;
                out_if.ready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    t_result seen;
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen.field_kind  = out_if.field_kind;
            seen.field_index = out_if.field_index;
            seen.field_value = out_if.field_value;
            seen.status      = out_if.status;
            results_seen++;
            if (awaited_fields.size() == 0) begin
                $display("%0t: expected no result, got kind %0d index %0d value 0x%0h status %0d",
                         $time, seen.field_kind, seen.field_index, seen.field_value,
                         seen.status);
                errors++;
            end else begin
                want = awaited_fields.pop_front();
                check_field("field_kind", 64'(want.field_kind), 64'(seen.field_kind));
                check_field("field_index", 64'(want.field_index), 64'(seen.field_index));
                check_field("field_value", want.field_value, seen.field_value);
                check_field("status", 64'(want.status), 64'(seen.status));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("compact_vote_message_parser: mismatch");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.data_byte      = '0;
        in_if.end_of_buffer  = 1'b0;
        out_if.ready         = 1'b0;
        errors               = 0;
        results_seen         = 0;
        idle_cycles          = 0;

        // early end on the very first root byte
        put_byte(8'h00);
        mark_end();
        // all-ones root, count above the lockout limit, trailing bytes
        repeat (8) put_byte(8'hFF);
        put_byte(8'h20);
        put_byte(8'h00);
        put_byte(8'hFF);
        mark_end();
        // zero root, non-canonical count that fails on the marked byte
        repeat (8) put_byte(8'h00);
        put_byte(8'h80);
        put_byte(8'h00);
        mark_end();

        while (byte_stream.size() < STREAM_ITEMS)
            add_message();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_stream.size() != 0 || awaited_fields.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (errors == 0)
            $display("compact_vote_message_parser: match");
        else
            $display("compact_vote_message_parser: mismatch");
        $finish;
    end

endmodule
